// File: hw/rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test package
// Widths, queue sizing and shared types for the prime test unit.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // Width of the signed candidate word and of the reported value.
  localparam int unsigned NumWidth   = 32;
  localparam int unsigned ValWidth   = NumWidth - 1;

  // A divisor never exceeds the square root of the largest positive value.
  localparam int unsigned DivWidth   = (NumWidth + 1) / 2;

  // The running square is kept at twice the divisor width, so it cannot wrap.
  localparam int unsigned SqWidth    = 2 * DivWidth;

  // Index of one bit of the value during the remainder sweep.
  localparam int unsigned BitWidth   = $clog2(ValWidth);

  // Decoupling queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrWidth  = $clog2(QueueDepth);
  localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);

  // Smallest prime.
  localparam logic [ValWidth-1:0] MinPrime = ValWidth'(2);

  // One classified word waiting for the back.
  typedef struct packed {
    logic                trivial;  // negative, zero or one: never prime
    logic [ValWidth-1:0] value;    // magnitude of a non-negative candidate
  } entry_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
  } q_status_t;

endpackage

// File: hw/rtl/tdpt_front.sv
// ----------------------------------------------------------------------------
// Trial division prime test front
// Accepts candidate words and classifies them before they are queued.
// ----------------------------------------------------------------------------
module tdpt_front (
  input  logic                              start_i,
  input  logic [tdpt_pkg::NumWidth-1:0]     candidate_i,
  input  tdpt_pkg::q_status_t               q_status_i,
  output logic                              busy_o,
  output logic                              push_o,
  output tdpt_pkg::entry_t                  entry_o
);

  // The front stalls only while the queue has no room.
  assign busy_o = q_status_i.full;
  assign push_o = start_i & ~q_status_i.full;

  // A negative word, zero or one needs no trial division at all.
  always_comb begin
    entry_o.value   = candidate_i[tdpt_pkg::ValWidth-1:0];
    entry_o.trivial = candidate_i[tdpt_pkg::NumWidth-1] |
                      (candidate_i[tdpt_pkg::ValWidth-1:0] < tdpt_pkg::MinPrime);
  end

endmodule

// File: hw/rtl/tdpt_queue.sv
// ----------------------------------------------------------------------------
// Trial division prime test queue
// Short first-in first-out store that decouples the front from the back.
// ----------------------------------------------------------------------------
module tdpt_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tdpt_pkg::entry_t     entry_i,
  input  logic                 pop_i,
  output tdpt_pkg::entry_t     entry_o,
  output logic                 empty_o,
  output tdpt_pkg::q_status_t  status_o
);

  tdpt_pkg::entry_t                    slots_q [tdpt_pkg::QueueDepth];
  logic [tdpt_pkg::QPtrWidth-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [tdpt_pkg::QCntWidth-1:0]      cnt_q, cnt_d;
  logic                                do_push, do_pop;

  assign do_push = push_i & (cnt_q != tdpt_pkg::QCntWidth'(tdpt_pkg::QueueDepth));
  assign do_pop  = pop_i & (cnt_q != '0);

  assign empty_o       = (cnt_q == '0);
  assign status_o.full = (cnt_q == tdpt_pkg::QCntWidth'(tdpt_pkg::QueueDepth));
  assign entry_o       = slots_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == tdpt_pkg::QPtrWidth'(tdpt_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == tdpt_pkg::QPtrWidth'(tdpt_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage needs no reset: a slot is only read after it was written.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= entry_i;
    end
  end

endmodule

// File: hw/rtl/tdpt_back.sv
// ----------------------------------------------------------------------------
// Trial division prime test back
// Runs the divisor loop with a bit-serial remainder unit and emits results.
// ----------------------------------------------------------------------------
module tdpt_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tdpt_pkg::entry_t                  entry_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output logic                              result_valid_o,
  output logic                              is_prime_o,
  output logic [tdpt_pkg::ValWidth-1:0]     prime_value_o
);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StCheck  = 3'b010,
    StDivide = 3'b100
  } state_e;

  state_e                            state_q, state_d;
  logic [tdpt_pkg::ValWidth-1:0]     n_q, n_d;
  logic [tdpt_pkg::DivWidth-1:0]     div_q, div_d;
  logic [tdpt_pkg::SqWidth-1:0]      sq_q, sq_d;
  logic [tdpt_pkg::DivWidth-1:0]     rem_q, rem_d;
  logic [tdpt_pkg::BitWidth-1:0]     bit_q, bit_d;
  logic                              res_valid_q, res_valid_d;
  logic                              res_prime_q, res_prime_d;
  logic [tdpt_pkg::ValWidth-1:0]     res_value_q, res_value_d;
  logic [tdpt_pkg::DivWidth:0]       rem_shift;
  logic [tdpt_pkg::DivWidth:0]       rem_sub;
  logic [tdpt_pkg::DivWidth-1:0]     rem_next;

  // One restoring remainder step: bring in the next bit, subtract if it fits.
  always_comb begin
    rem_shift = {rem_q, n_q[bit_q]};
    rem_sub   = rem_shift - {1'b0, div_q};
    rem_next  = rem_shift[tdpt_pkg::DivWidth:0] >= {1'b0, div_q} ?
                rem_sub[tdpt_pkg::DivWidth-1:0] : rem_shift[tdpt_pkg::DivWidth-1:0];
  end

  // Sequencer for the divisor loop.
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    div_d       = div_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    res_valid_d = 1'b0;
    res_prime_d = res_prime_q;
    res_value_d = res_value_q;
    pop_o       = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          n_d   = entry_i.value;
          if (entry_i.trivial) begin
            res_valid_d = 1'b1;
            res_prime_d = 1'b0;
            res_value_d = '0;
          end else begin
            div_d   = tdpt_pkg::DivWidth'(2);
            sq_d    = tdpt_pkg::SqWidth'(4);
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        // Once the square passes the value, no divisor was found.
        if (sq_q > tdpt_pkg::SqWidth'(n_q)) begin
          res_valid_d = 1'b1;
          res_prime_d = 1'b1;
          res_value_d = n_q;
          state_d     = StIdle;
        end else begin
          rem_d   = '0;
          bit_d   = tdpt_pkg::BitWidth'(tdpt_pkg::ValWidth - 1);
          state_d = StDivide;
        end
      end
      StDivide: begin
        rem_d = rem_next;
        if (bit_q == '0) begin
          if (rem_next == '0) begin
            res_valid_d = 1'b1;
            res_prime_d = 1'b0;
            res_value_d = '0;
            state_d     = StIdle;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_d    = sq_q + tdpt_pkg::SqWidth'({div_q, 1'b1});
            div_d   = div_q + 1'b1;
            state_d = StCheck;
          end
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    div_q       <= div_d;
    sq_q        <= sq_d;
    rem_q       <= rem_d;
    bit_q       <= bit_d;
    res_prime_q <= res_prime_d;
    res_value_q <= res_value_d;
  end

  assign result_valid_o = res_valid_q;
  assign is_prime_o     = res_prime_q;
  assign prime_value_o  = res_value_q;

  // In the check state the running square matches the current divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCheck) |-> (sq_q == tdpt_pkg::SqWidth'(div_q) * tdpt_pkg::SqWidth'(div_q)))
    else $error("running square out of step with divisor");

  // The partial remainder stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivide) |-> (rem_q < div_q))
    else $error("partial remainder not reduced");

  // A prime result carries a value of at least two, a non-prime carries zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_prime_q ? (res_value_q >= tdpt_pkg::MinPrime) : (res_value_q == '0)))
    else $error("result value inconsistent with prime flag");

endmodule

// File: hw/rtl/trial_division_prime_test_unit.sv
// ----------------------------------------------------------------------------
// Trial division prime test unit
// Decides by trial division whether a signed word is prime.
// ----------------------------------------------------------------------------
//  Channel   Signals                                Direction  Transfer
//  command   start, busy, candidate_i               in         start & ~busy
//  result    result_valid_o, is_prime_o,            out        one-cycle strobe
//            prime_value_o
//
// A word that is negative, zero or one needs no trial division; the back
// pops it and registers a non-prime result. Otherwise each trial divisor
// takes one square check in StCheck and a remainder sweep over every value
// bit in StDivide, and a prime p tries every divisor up to floor(sqrt(p)).
// Two words can wait in the queue while the back works; busy rises when it
// is full. The receiver cannot stall results. Reset clears all control state.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [tdpt_pkg::NumWidth-1:0]     candidate_i,
  output logic                              result_valid_o,
  output logic                              is_prime_o,
  output logic [tdpt_pkg::ValWidth-1:0]     prime_value_o
);

  logic                 push, pop, empty;
  tdpt_pkg::entry_t     entry_in, entry_out;
  tdpt_pkg::q_status_t  q_status;

  // Front: accept and classify.
  tdpt_front u_front (
    .start_i     (start),
    .candidate_i (candidate_i),
    .q_status_i  (q_status),
    .busy_o      (busy),
    .push_o      (push),
    .entry_o     (entry_in)
  );

  // Queue between the two halves.
  tdpt_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry_in),
    .pop_i    (pop),
    .entry_o  (entry_out),
    .empty_o  (empty),
    .status_o (q_status)
  );

  // Back: divisor loop and result register.
  tdpt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (entry_out),
    .empty_i        (empty),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .is_prime_o     (is_prime_o),
    .prime_value_o  (prime_value_o)
  );

endmodule

// File: sim/trial_division_prime_test_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test unit testbench
// Feeds signed candidate words through the command handshake at random
// pace and checks each result strobe against a scoreboard. The scoreboard
// forms its own verdict by trial division at double width. Most random
// words are small or have a tiny factor, to keep the run short. A single
// directed word, the largest positive prime, exercises the longest path.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit_test;
  localparam int unsigned NumWidth = tdpt_pkg::NumWidth;
  localparam int unsigned ValWidth = tdpt_pkg::ValWidth;

  localparam int unsigned StallLimit = 6000000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomWords = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [NumWidth-1:0] candidate_i = '0;
  logic                result_valid_o;
  logic                is_prime_o;
  logic [ValWidth-1:0] prime_value_o;

  // One expected verdict.
  typedef struct {
    logic                prime;
    logic [ValWidth-1:0] value;
  } verdict_t;

  // Holds the verdicts of accepted words in order and checks each strobe.
  class prime_scoreboard;
    verdict_t verdict_q[$];
    int       mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Trial division with the square formed at 64 bits, so it cannot wrap.
    function verdict_t predict_verdict(logic [NumWidth-1:0] word);
      verdict_t        v;
      longint unsigned n;
      longint unsigned d;
      v.prime = 1'b0;
      v.value = '0;
      n = longint'(word);
      if (!word[NumWidth-1] && n >= 2) begin
        v.prime = 1'b1;
        for (d = 2; d * d <= n; d++) begin
          if (n % d == 0) begin
            v.prime = 1'b0;
            break;
          end
        end
      end
      if (v.prime) begin
        v.value = word[ValWidth-1:0];
      end
      return v;
    endfunction

    function void note_candidate(logic [NumWidth-1:0] word);
      verdict_q.push_back(predict_verdict(word));
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t ns: %s", $realtime, what);
      mismatch_count++;
    endtask

    task check_word(logic prime, logic [ValWidth-1:0] value);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result prime=%b value=%0d", prime, value));
      end else begin
        v = verdict_q.pop_front();
        if (prime !== v.prime) begin
          report_mismatch($sformatf("is_prime %b, expected %b", prime, v.prime));
        end
        if (value !== v.value) begin
          report_mismatch($sformatf("prime_value %0d, expected %0d", value, v.value));
        end
      end
    endtask

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  prime_scoreboard sb;
  int unsigned     stall_count = 0;

  trial_division_prime_test_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .candidate_i    (candidate_i),
    .result_valid_o (result_valid_o),
    .is_prime_o     (is_prime_o),
    .prime_value_o  (prime_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Check every result word on the edge that ends its strobe.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_word(is_prime_o, prime_value_o);
    end
  end

  // Watchdog: restarts on any handshake, gives up after a long silence.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_count <= 0;
    end else if (stall_count >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Present one word after a random gap and hold it until it is taken.
  task send_candidate(logic [NumWidth-1:0] word);
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    candidate_i <= word;
    do begin
      @(posedge clk_i);
    end while (!(start && !busy));
    sb.note_candidate(word);
  endtask

  // Random word: mostly small values; large non-negative ones carry a factor of 2 or 3, others are negative.
  function logic [NumWidth-1:0] random_candidate();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      return NumWidth'($urandom_range(0, 2000));
    end else if (pick < 60) begin
      return NumWidth'($urandom_range(2001, 60000));
    end else if (pick < 68) begin
      return ($urandom() & 32'h3FFF_FFFF) << 1;
    end else if (pick < 75) begin
      return ($urandom() % 32'd715827882) * 32'd3;
    end else if (pick < 90) begin
      return $urandom() | 32'h8000_0000;
    end else begin
      return NumWidth'($urandom_range(0, 4));
    end
  endfunction

  initial begin
    logic [NumWidth-1:0] directed_q[$];
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words include values below two, the sign bit, squares of primes
    // at the loop bound, large even and odd composites, and the largest prime.
    directed_q = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'hFFFF_FFF9, 32'd5, 32'd25, 32'd49, 32'd121, 32'd63001,
                   32'd97, 32'd7919, 32'd65521, 32'd65536, 32'h5555_5555,
                   32'h2AAA_AAAA, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'd17};
    foreach (directed_q[i]) begin
      send_candidate(directed_q[i]);
    end
    repeat (RandomWords) begin
      send_candidate(random_candidate());
    end
    start <= 1'b0;

    // Drain, then keep watching for any stray strobe.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
